@@ rtl/slot_pool_free_list_allocator_assert.svh @@
// Assertion macros for the slot pool RTL.
// Expects clk_i and rst_ni in the scope of the module that expands them.
`ifndef SLOT_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPFL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPFL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spfl_pkg.sv @@
// Shared types and constants for the slot pool allocator.
// No dependencies.
`timescale 1ns / 1ps

package spfl_pkg;

  typedef enum logic [2:0] {
    FN_ALLOC     = 3'd0,
    FN_FREE      = 3'd1,
    FN_CLEAR     = 3'd2,
    FN_FIND_NEXT = 3'd3,
    FN_FIND_PREV = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2,
    STS_NONE = 2'd3
  } status_e;

  localparam int EB_W = 13;
  localparam logic [EB_W-1:0] EB_MIN   = 13'd16;
  localparam logic [EB_W-1:0] EB_MAX   = 13'd4096;
  localparam logic [EB_W-1:0] EB_RESET = 13'd16;

  localparam int FUNC_W   = 3;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int OFFS_W   = 22;
  localparam int USED_W   = 11;

  // Controls into the walk cursor
  typedef struct packed {
    logic load;
    logic step;
    logic down;
  } cur_ctrl_t;

  // Status back from the walk cursor
  typedef struct packed {
    logic at_end;
  } cur_flags_t;

endpackage

@@ rtl/spfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spfl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/spfl_cursor.sv @@
// Walk cursor: one shared increment/decrement and end compare, stepped by the sequencer.
// Depends on spfl_pkg.
`timescale 1ns / 1ps

module spfl_cursor #(
  parameter int IW = 10,
  parameter int HW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spfl_pkg::cur_ctrl_t    ctrl_i,
  input  logic [IW-1:0]          load_val_i,
  input  logic [HW-1:0]          bound_i,
  output logic [IW-1:0]          cur_o,
  output logic [IW-1:0]          next_o,
  output spfl_pkg::cur_flags_t   flags_o
);

  localparam int NW = IW + 1;

  logic [IW-1:0] cur_q, cur_d;
  logic          down_q, down_d;
  logic [NW-1:0] sum;

  // Shared adder: +1 walking up, -1 walking down
  assign sum = {1'b0, cur_q} + (down_q ? {NW{1'b1}} : NW'(1));

  assign next_o         = sum[IW-1:0];
  assign cur_o          = cur_q;
  assign flags_o.at_end = down_q ? (cur_q == '0) : (sum >= NW'(bound_i));

  always_comb begin
    cur_d  = cur_q;
    down_d = down_q;
    if (ctrl_i.load) begin
      cur_d  = load_val_i;
      down_d = ctrl_i.down;
    end else if (ctrl_i.step) begin
      cur_d = sum[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      down_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      down_q <= down_d;
    end
  end

endmodule

@@ rtl/slot_pool_free_list_allocator.sv @@
// Channel  Direction  Handshake              Payload
// in       to block   in_valid_i/in_stall_o  func_i, slot_i
// out      from block out_valid_o/out_stall_i status_o, slot_out_o, byte_offset_o, used_slots_o
// cfg      to block   cfg_we_i               cfg_wdata_i (elem_bytes)
//
// One transaction at a time, stepped from execute to emit, where the result register loads.
// Alloc from the mark, clear, undefined codes, free at or above the mark,
// find next at or above the mark and find previous on an empty pool go straight to emit;
// alloc from the free list adds a pop; free below the mark, live or not, adds probe and check;
// other finds probe, then check slot after slot, one live-mark memory read per slot.
// Reset empties the pool; slot memories are not cleared and need no sweep.
// A stalled result holds in the output register; the next input is taken meanwhile.
// Depends on spfl_pkg, spfl_ram, spfl_cursor and the assertion header.
`timescale 1ns / 1ps

`include "slot_pool_free_list_allocator_assert.svh"

module slot_pool_free_list_allocator #(
  parameter int SLOTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spfl_pkg::EB_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [spfl_pkg::FUNC_W-1:0]      func_i,
  input  logic [spfl_pkg::SLOT_W-1:0]      slot_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [spfl_pkg::STATUS_W-1:0]    status_o,
  output logic [spfl_pkg::SLOT_W-1:0]      slot_out_o,
  output logic [spfl_pkg::OFFS_W-1:0]      byte_offset_o,
  output logic [spfl_pkg::USED_W-1:0]      used_slots_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int CW = (HW > spfl_pkg::SLOT_W) ? HW : spfl_pkg::SLOT_W;
  localparam int PW = IW + spfl_pkg::EB_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_PROBE,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e                         state_q, state_d;
  logic [spfl_pkg::FUNC_W-1:0]    func_q, func_d;
  logic [CW-1:0]                  slot_q, slot_d;
  logic [HW-1:0]                  hw_q, hw_d;
  logic [IW-1:0]                  head_q, head_d;
  logic                           nonempty_q, nonempty_d;
  logic [spfl_pkg::EB_W-1:0]      eb_q, eb_d;
  spfl_pkg::status_e              res_status_q, res_status_d;
  logic [IW-1:0]                  res_slot_q, res_slot_d;
  logic                           out_valid_q, out_valid_d;
  logic [spfl_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [spfl_pkg::SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [spfl_pkg::OFFS_W-1:0]    out_offs_q, out_offs_d;
  logic [spfl_pkg::USED_W-1:0]    out_used_q, out_used_d;

  spfl_pkg::cur_ctrl_t  cur_ctrl;
  spfl_pkg::cur_flags_t cur_flags;
  logic [IW-1:0]        cur_load_val;
  logic [IW-1:0]        cursor;
  logic [IW-1:0]        cur_next;

  logic          live_we;
  logic [IW-1:0] live_waddr;
  logic          live_wdata;
  logic [IW-1:0] live_raddr;
  logic          live_rdata;
  logic          link_we;
  logic [IW:0]   link_wdata;
  logic [IW:0]   link_rdata;

  logic          s_lt_hw;
  logic [PW-1:0] prod;

  spfl_cursor #(
    .IW (IW),
    .HW (HW)
  ) u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cur_ctrl),
    .load_val_i (cur_load_val),
    .bound_i    (hw_q),
    .cur_o      (cursor),
    .next_o     (cur_next),
    .flags_o    (cur_flags)
  );

  // Live marks, one bit per slot
  spfl_ram #(
    .W     (1),
    .DEPTH (SLOTS)
  ) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .raddr_i (live_raddr),
    .rdata_o (live_rdata)
  );

  // Free-list links: {last, next}
  spfl_ram #(
    .W     (IW + 1),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (cursor),
    .wdata_i (link_wdata),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  // While walking, fetch the following slot so one probe lands per cycle
  assign live_raddr = (state_q == S_CHECK) ? cur_next : cursor;
  assign link_wdata = {!nonempty_q, head_q};
  assign s_lt_hw    = slot_q < CW'(hw_q);
  assign prod       = PW'(res_slot_q) * PW'(eb_q);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    slot_d       = slot_q;
    hw_d         = hw_q;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    eb_d         = eb_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_offs_d   = out_offs_q;
    out_used_d   = out_used_q;
    cur_ctrl     = '0;
    cur_load_val = IW'(slot_q);
    live_we      = 1'b0;
    live_waddr   = cursor;
    live_wdata   = 1'b0;
    link_we      = 1'b0;

    // Clamp the slot size as it is written
    if (cfg_we_i) begin
      if (cfg_wdata_i < spfl_pkg::EB_MIN) begin
        eb_d = spfl_pkg::EB_MIN;
      end else if (cfg_wdata_i > spfl_pkg::EB_MAX) begin
        eb_d = spfl_pkg::EB_MAX;
      end else begin
        eb_d = cfg_wdata_i;
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          slot_d  = CW'(slot_i);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_EMIT;
        res_status_d = spfl_pkg::STS_OK;
        res_slot_d   = '0;
        case (func_q)
          spfl_pkg::FN_ALLOC: begin
            if (nonempty_q) begin
              state_d = S_POP;
            end else if (hw_q < HW'(SLOTS)) begin
              res_slot_d = IW'(hw_q);
              hw_d       = hw_q + HW'(1);
              live_we    = 1'b1;
              live_waddr = IW'(hw_q);
              live_wdata = 1'b1;
            end else begin
              res_status_d = spfl_pkg::STS_FULL;
            end
          end
          spfl_pkg::FN_FREE: begin
            if (s_lt_hw) begin
              cur_ctrl.load = 1'b1;
              state_d       = S_PROBE;
            end else begin
              res_status_d = spfl_pkg::STS_BAD;
            end
          end
          spfl_pkg::FN_CLEAR: begin
            hw_d       = '0;
            head_d     = '0;
            nonempty_d = 1'b0;
          end
          spfl_pkg::FN_FIND_NEXT: begin
            if (s_lt_hw) begin
              cur_ctrl.load = 1'b1;
              state_d       = S_PROBE;
            end else begin
              res_status_d = spfl_pkg::STS_NONE;
            end
          end
          spfl_pkg::FN_FIND_PREV: begin
            if (hw_q == '0) begin
              res_status_d = spfl_pkg::STS_NONE;
            end else begin
              // Start at the top live candidate when beyond the mark
              cur_load_val  = s_lt_hw ? IW'(slot_q) : IW'(hw_q - HW'(1));
              cur_ctrl.load = 1'b1;
              cur_ctrl.down = 1'b1;
              state_d       = S_PROBE;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        res_slot_d = head_q;
        live_we    = 1'b1;
        live_waddr = head_q;
        live_wdata = 1'b1;
        if (link_rdata[IW]) begin
          nonempty_d = 1'b0;
          head_d     = '0;
        end else begin
          head_d = link_rdata[IW-1:0];
        end
        state_d = S_EMIT;
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (func_q == spfl_pkg::FN_FREE) begin
          if (live_rdata) begin
            link_we    = 1'b1;
            live_we    = 1'b1;
            head_d     = cursor;
            nonempty_d = 1'b1;
            res_slot_d = cursor;
          end else begin
            res_status_d = spfl_pkg::STS_BAD;
          end
          state_d = S_EMIT;
        end else if (live_rdata) begin
          res_slot_d = cursor;
          state_d    = S_EMIT;
        end else if (cur_flags.at_end) begin
          res_status_d = spfl_pkg::STS_NONE;
          state_d      = S_EMIT;
        end else begin
          cur_ctrl.step = 1'b1;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = spfl_pkg::SLOT_W'(res_slot_q);
          out_offs_d   = spfl_pkg::OFFS_W'(prod);
          out_used_d   = spfl_pkg::USED_W'(hw_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= '0;
      slot_q       <= '0;
      hw_q         <= '0;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      eb_q         <= spfl_pkg::EB_RESET;
      res_status_q <= spfl_pkg::STS_OK;
      res_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_offs_q   <= '0;
      out_used_q   <= '0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      slot_q       <= slot_d;
      hw_q         <= hw_d;
      head_q       <= head_d;
      nonempty_q   <= nonempty_d;
      eb_q         <= eb_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_offs_q   <= out_offs_d;
      out_used_q   <= out_used_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_out_o    = out_slot_q;
  assign byte_offset_o = out_offs_q;
  assign used_slots_o  = out_used_q;

  `SPFL_ASSERT_IMP(a_hw_bound, 1'b1, hw_q <= HW'(SLOTS), "high-water mark above pool size")
  `SPFL_ASSERT_IMP(a_empty_head, !nonempty_q, head_q == '0, "free head set on an empty list")
  `SPFL_ASSERT_IMP(a_pop_nonempty, state_q == S_POP, nonempty_q, "pop from an empty free list")
  `SPFL_ASSERT_NXT(a_accept_exec, in_valid_i && !in_stall_o, state_q == S_EXEC, "accept lost")

endmodule

@@ tb/slot_pool_checker.sv @@
// Checker for the slot pool allocator: predicts each result from the accepted transactions
// and compares it with what the block returns. Depends on spfl_pkg.
`timescale 1ns / 1ps

module slot_pool_checker
  import spfl_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [EB_W-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [SLOT_W-1:0]   slot_out_i,
  input  logic [OFFS_W-1:0]   byte_offset_i,
  input  logic [USED_W-1:0]   used_slots_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFS_W-1:0]   offs;
    logic [USED_W-1:0]   used;
  } pool_result_t;

  // Own copy of the pool
  logic [EB_W-1:0]   elem_bytes;
  logic [SLOT_W-1:0] list_head;
  logic              list_nonempty;
  logic [USED_W-1:0] high_mark;
  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic              tail_mem [SLOTS];
  logic              live_mem [SLOTS];

  pool_result_t awaited_results [$];
  int           failures;

  function automatic pool_result_t make_result(status_e st, logic has_slot,
                                               logic [SLOT_W-1:0] s);
    logic [EB_W-1:0] eb;
    pool_result_t    r;
    eb = (elem_bytes < EB_MIN) ? EB_MIN : ((elem_bytes > EB_MAX) ? EB_MAX : elem_bytes);
    r.status = st;
    r.slot   = has_slot ? s : '0;
    r.offs   = has_slot ? OFFS_W'(32'(s) * 32'(eb)) : '0;
    r.used   = high_mark;
    return r;
  endfunction

  task automatic predict_pool_op(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] s,
                                 output pool_result_t r);
    int i;
    case (fn)
      FN_ALLOC: begin
        if (list_nonempty) begin
          i = int'(list_head);
          if (tail_mem[i]) begin
            list_nonempty = 1'b0;
            list_head     = '0;
          end else begin
            list_head = link_mem[i];
          end
          live_mem[i] = 1'b1;
          r = make_result(STS_OK, 1'b1, SLOT_W'(i));
        end else if (int'(high_mark) < SLOTS) begin
          i = int'(high_mark);
          high_mark = high_mark + 1'b1;
          live_mem[i] = 1'b1;
          r = make_result(STS_OK, 1'b1, SLOT_W'(i));
        end else begin
          r = make_result(STS_FULL, 1'b0, '0);
        end
      end
      FN_FREE: begin
        if (s >= high_mark || int'(s) >= SLOTS || !live_mem[s]) begin
          r = make_result(STS_BAD, 1'b0, '0);
        end else begin
          link_mem[s]   = list_head;
          tail_mem[s]   = !list_nonempty;
          list_head     = s;
          list_nonempty = 1'b1;
          live_mem[s]   = 1'b0;
          r = make_result(STS_OK, 1'b1, s);
        end
      end
      FN_CLEAR: begin
        high_mark     = '0;
        list_head     = '0;
        list_nonempty = 1'b0;
        r = make_result(STS_OK, 1'b0, '0);
      end
      FN_FIND_NEXT: begin
        r = make_result(STS_NONE, 1'b0, '0);
        for (i = int'(s); i < int'(high_mark) && i < SLOTS; i++) begin
          if (live_mem[i]) begin
            r = make_result(STS_OK, 1'b1, SLOT_W'(i));
            break;
          end
        end
      end
      FN_FIND_PREV: begin
        r = make_result(STS_NONE, 1'b0, '0);
        if (high_mark != '0) begin
          // start below the mark when the position lies past it
          i = (int'(s) < int'(high_mark)) ? int'(s) : int'(high_mark) - 1;
          while (i >= 0) begin
            if (i < SLOTS && live_mem[i]) begin
              r = make_result(STS_OK, 1'b1, SLOT_W'(i));
              break;
            end
            i--;
          end
        end
      end
      default: begin
        r = make_result(STS_OK, 1'b0, '0);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pool_result_t want;
    if (!rst_ni) begin
      elem_bytes    = EB_RESET;
      list_head     = '0;
      list_nonempty = 1'b0;
      high_mark     = '0;
      for (int k = 0; k < SLOTS; k++) begin
        link_mem[k] = '0;
        tail_mem[k] = 1'b0;
        live_mem[k] = 1'b0;
      end
      awaited_results.delete();
      failures  = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // retire the result first: it belongs to an earlier transaction
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: unexpected result: status %0d slot %0d offset %0d used %0d",
                     $realtime, status_i, slot_out_i, byte_offset_i, used_slots_i);
          end
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status || slot_out_i !== want.slot ||
              byte_offset_i !== want.offs || used_slots_i !== want.used) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: result mismatch: expected status %0d slot %0d offset %0d used %0d",
                       $realtime, want.status, want.slot, want.offs, want.used);
              $display("%0t:                  actual status %0d slot %0d offset %0d used %0d",
                       $realtime, status_i, slot_out_i, byte_offset_i, used_slots_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_pool_op(func_i, slot_i, want);
        awaited_results.push_back(want);
      end
      if (cfg_we_i) begin
        elem_bytes = cfg_wdata_i;
      end
      pending_o <= awaited_results.size();
      errors_o  <= failures;
    end
  end

endmodule

@@ tb/tb_slot_pool_free_list_allocator.sv @@
// Top of the slot pool allocator testbench: clock, reset, stimulus, stalls and verdict.
// Depends on spfl_pkg, slot_pool_free_list_allocator and slot_pool_checker.
`timescale 1ns / 1ps

module tb_slot_pool_free_list_allocator;
  import spfl_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_LIMIT  = 8000;

  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [EB_W-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i      = '0;
  logic [SLOT_W-1:0]   slot_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_out_o;
  logic [OFFS_W-1:0]   byte_offset_o;
  logic [USED_W-1:0]   used_slots_o;

  logic calm = 1'b0;
  int   pending;
  int   errors;

  slot_pool_free_list_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_out_o   (slot_out_o),
    .byte_offset_o(byte_offset_o),
    .used_slots_o (used_slots_o)
  );

  slot_pool_checker #(
    .SLOTS(SLOTS)
  ) pool_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .slot_out_i   (slot_out_o),
    .byte_offset_i(byte_offset_o),
    .used_slots_i (used_slots_o),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 32);
  end

  // Mostly low slots so that frees and finds hit a small, busy pool
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 99) < 85) begin
      return SLOT_W'($urandom_range(0, 40));
    end
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] s);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    slot_i     <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every awaited result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [EB_W-1:0] eb_plan [7];
    int              pick;
    eb_plan = '{13'd0, '1, EB_MAX, EB_MIN - 1'b1, EB_MAX + 1'b1, EB_MIN, '0};
    eb_plan[6] = EB_W'($urandom_range(0, 8191));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pool, reuse order, bad and double frees, finds on both sides of the mark
    send_op(FN_FIND_NEXT, 10'd0);
    send_op(FN_FIND_PREV, 10'd1023);
    send_op(FN_FREE, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_FREE, 10'd1);
    send_op(FN_FREE, 10'd1);
    send_op(FN_FREE, 10'd1023);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_FREE, 10'd0);
    send_op(FN_FREE, 10'd2);
    send_op(FN_FIND_NEXT, 10'd0);
    send_op(FN_FIND_PREV, 10'd1023);
    send_op(FN_FIND_PREV, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_FIND_NEXT, 10'd1023);
    for (int f = int'(FN_UNUSED_FIRST); f <= int'(FN_UNUSED_LAST); f++) begin
      send_op(FUNC_W'(f), 10'd0);
    end
    send_op(FN_CLEAR, 10'd0);
    send_op(FN_ALLOC, 10'd0);
    send_op(FN_FREE, 10'd0);

    for (int p = 0; p < 7; p++) begin
      drain();
      repeat (4) @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= eb_plan[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      calm     <= (p == 4);

      if (p == 1) begin
        // run the pool to full, punch holes, refill past full
        send_op(FN_CLEAR, SLOT_W'($urandom));
        repeat (SLOTS + 2) send_op(FN_ALLOC, SLOT_W'($urandom));
        repeat (24) send_op(FN_FREE, SLOT_W'($urandom_range(0, SLOTS - 1)));
        repeat (8) begin
          send_op(($urandom_range(0, 1) != 0) ? FN_FIND_NEXT : FN_FIND_PREV,
                  SLOT_W'($urandom_range(0, SLOTS - 1)));
        end
        repeat (26) send_op(FN_ALLOC, SLOT_W'($urandom));
        send_op(FN_FIND_PREV, 10'd1023);
        send_op(FN_FIND_NEXT, 10'd1023);
        send_op(FN_CLEAR, SLOT_W'($urandom));
      end else begin
        for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
          pick = $urandom_range(0, 99);
          if (pick < 38) begin
            send_op(FN_ALLOC, SLOT_W'($urandom));
          end else if (pick < 68) begin
            send_op(FN_FREE, pick_slot());
          end else if (pick < 80) begin
            send_op(FN_FIND_NEXT, pick_slot());
          end else if (pick < 92) begin
            send_op(FN_FIND_PREV, pick_slot());
          end else if (pick < 96) begin
            send_op(FN_CLEAR, SLOT_W'($urandom));
          end else begin
            send_op(FUNC_W'($urandom_range(int'(FN_UNUSED_FIRST), int'(FN_UNUSED_LAST))),
                    SLOT_W'($urandom));
          end
        end
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
